// ===== rtl/core/internal_collision_arbiter_unit_defines.svh =====
// Assertion macros for the internal collision arbiter.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef INTERNAL_COLLISION_ARBITER_UNIT_DEFINES_SVH
`define INTERNAL_COLLISION_ARBITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ICA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ICA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ica_pkg.sv =====
// Shared types and constants for the internal collision arbiter.
// No dependencies.
package ica_pkg;

    localparam int NUM_SLOTS_DEF = 4;
    localparam int TIME_BITS_DEF = 32;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 2;
    localparam int FIELD_T_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int CMASK_W    = 4;

    // slot, start_time, current_time packed, rounded up to bytes
    localparam int IN_TDATA_W  = ((SLOT_W + 2 * FIELD_T_W + 7) / 8) * 8;
    // status, grant_valid, grant_slot, collision_mask, next_valid, next_time
    localparam int OUT_RAW_W   = STATUS_W + 1 + SLOT_W + CMASK_W + 1 + FIELD_T_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_CANCEL   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_PENDING   = 2'd1,
        STATUS_TOO_EARLY = 2'd2
    } t_status;

endpackage

// ===== rtl/core/internal_collision_arbiter_unit.sv =====
// Internal collision arbiter: a request passes through the input register,
// one pass of compare logic and the result register.
// Throughput: one request per cycle, set by the slot compare and
// earliest-time search; back-pressure stalls only when the result is not taken.
// Reset (i_rst_n low, synchronous): all slots idle, no tick seen, last tick 0,
// both register stages empty. Stored slot times are not cleared.
module internal_collision_arbiter_unit #(
    parameter int NUM_SLOTS = ica_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = ica_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [1:0] slot, [33:2] start_time, [65:34] current_time, upper bits zero
    input  logic [ica_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] cmd
    input  logic [ica_pkg::CMD_W-1:0]      i_s_axis_tuser,
    // result side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [1:0] status, [2] grant_valid, [4:3] grant_slot, [8:5] collision_mask,
    // [9] next_valid, [41:10] next_time, upper bits zero
    output logic [ica_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

`include "internal_collision_arbiter_unit_defines.svh"

    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MASK_KEEP = (NUM_SLOTS < ica_pkg::CMASK_W) ? NUM_SLOTS : ica_pkg::CMASK_W;
    localparam int SLOT_W    = ica_pkg::SLOT_W;
    localparam int FT_W      = ica_pkg::FIELD_T_W;

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic                    r_in_valid;
    logic [ica_pkg::CMD_W-1:0] r_cmd;
    logic [SLOT_W-1:0]       r_slot;
    logic [TIME_BITS-1:0]    r_start;
    logic [TIME_BITS-1:0]    r_now;

    // ------------------------------------------------------------------
    // Slot state
    // ------------------------------------------------------------------
    logic [NUM_SLOTS-1:0]    r_flag;
    logic [TIME_BITS-1:0]    r_time [NUM_SLOTS];
    logic [TIME_BITS-1:0]    r_last;
    logic                    r_seen;

    logic [NUM_SLOTS-1:0]    n_flag;
    logic [TIME_BITS-1:0]    n_time [NUM_SLOTS];
    logic [TIME_BITS-1:0]    n_last;
    logic                    n_seen;

    // ------------------------------------------------------------------
    // Result register stage
    // ------------------------------------------------------------------
    logic                          r_out_valid;
    logic [ica_pkg::STATUS_W-1:0]  r_out_status;
    logic                          r_out_gvalid;
    logic [SLOT_W-1:0]             r_out_gslot;
    logic [ica_pkg::CMASK_W-1:0]   r_out_cmask;
    logic                          r_out_nvalid;
    logic [FT_W-1:0]               r_out_ntime;

    logic out_free;
    logic proc_fire;
    logic in_fire;

    // Result stage frees up when empty or taken this cycle; the input stage
    // moves forward whenever the result stage can take its item.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc_fire       = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Capture the request payload; times are held modulo 2^TIME_BITS.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= i_s_axis_tuser;
            r_slot  <= i_s_axis_tdata[SLOT_W-1:0];
            r_start <= TIME_BITS'(i_s_axis_tdata[SLOT_W +: FT_W]);
            r_now   <= TIME_BITS'(i_s_axis_tdata[SLOT_W + FT_W +: FT_W]);
        end
    end

    // ------------------------------------------------------------------
    // Command decode and slot update
    // ------------------------------------------------------------------
    logic                   slot_ok;
    logic [IDX_W-1:0]       slot_idx;
    logic [NUM_SLOTS-1:0]   match;
    logic [NUM_SLOTS-1:0]   due;
    ica_pkg::t_status       status;

    assign slot_ok  = (32'(r_slot) < 32'(NUM_SLOTS));
    assign slot_idx = IDX_W'(r_slot);

    // Per-slot exact time match against the tick time.
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            match[k] = (r_time[k] == r_now);
        end
    end

    always_comb begin
        n_flag = r_flag;
        n_time = r_time;
        n_last = r_last;
        n_seen = r_seen;
        status = ica_pkg::STATUS_OK;
        due    = '0;
        unique case (ica_pkg::t_cmd'(r_cmd))
            ica_pkg::CMD_SCHEDULE: begin
                // Pending check wins over the too-early check; out-of-range
                // slots fall through with status ok and no change.
                if (slot_ok) begin
                    if (r_flag[slot_idx]) begin
                        status = ica_pkg::STATUS_PENDING;
                    end else if (r_seen && (r_start <= r_last)) begin
                        status = ica_pkg::STATUS_TOO_EARLY;
                    end else begin
                        n_flag[slot_idx] = 1'b1;
                        n_time[slot_idx] = r_start;
                    end
                end
            end
            ica_pkg::CMD_CANCEL: begin
                if (slot_ok) begin
                    n_flag[slot_idx] = 1'b0;
                end
            end
            ica_pkg::CMD_TICK: begin
                // Resolve exact matches only; earlier slots stay pending.
                due    = r_flag & match;
                n_flag = r_flag & ~due;
                n_last = r_now;
                n_seen = 1'b1;
            end
            ica_pkg::CMD_NOP: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Grant to the lowest due slot, collisions to the rest
    // ------------------------------------------------------------------
    logic [NUM_SLOTS-1:0]       grant_oh;
    logic [NUM_SLOTS-1:0]       coll;
    logic [IDX_W-1:0]           grant_idx;
    logic                       grant_valid;
    logic [ica_pkg::CMASK_W-1:0] cmask;

    assign grant_oh    = due & (~due + NUM_SLOTS'(1));
    assign coll        = due & ~grant_oh;
    assign grant_valid = |due;
    // Collision bits above the field's four slots are dropped.
    assign cmask       = ica_pkg::CMASK_W'(coll[MASK_KEEP-1:0]);

    always_comb begin
        grant_idx = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (grant_oh[k]) begin
                grant_idx = grant_idx | IDX_W'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Earliest pending time after the update: a slot is a minimum when no
    // other pending slot is strictly earlier; all minima share one value.
    // ------------------------------------------------------------------
    logic [NUM_SLOTS-1:0]   is_min;
    logic [TIME_BITS-1:0]   next_t;
    logic                   next_valid;

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            is_min[k] = n_flag[k];
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (n_flag[j] && (n_time[j] < n_time[k])) begin
                    is_min[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        next_t = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (is_min[k]) begin
                next_t = next_t | n_time[k];
            end
        end
    end

    assign next_valid = |n_flag;

    // ------------------------------------------------------------------
    // State and result registers advance together on each processed request
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            r_last <= '0;
            r_seen <= 1'b0;
        end else if (proc_fire) begin
            r_flag <= n_flag;
            r_last <= n_last;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_time <= n_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_status <= status;
            r_out_gvalid <= grant_valid;
            r_out_gslot  <= SLOT_W'(grant_idx);
            r_out_cmask  <= cmask;
            r_out_nvalid <= next_valid;
            r_out_ntime  <= FT_W'(next_t);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ica_pkg::OUT_TDATA_W'({r_out_ntime, r_out_nvalid, r_out_cmask,
                                                    r_out_gslot, r_out_gvalid, r_out_status});

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ICA_ASSERT_NOW(a_coll_needs_grant, i_clk, i_rst_n, r_out_valid && (r_out_cmask != '0), r_out_gvalid, "collision reported without a grant")
    `ICA_ASSERT_NOW(a_refused_no_grant, i_clk, i_rst_n, r_out_valid && (r_out_status != ica_pkg::STATUS_OK), !r_out_gvalid && (r_out_cmask == '0), "refused schedule carries grant or collision")
    `ICA_ASSERT_NEXT(a_next_valid_flags, i_clk, i_rst_n, proc_fire, r_out_valid && (r_out_nvalid == (|r_flag)), "next_valid disagrees with slot flags")
    `ICA_ASSERT_NOW(a_idle_time_zero, i_clk, i_rst_n, r_out_valid && !r_out_nvalid, r_out_ntime == '0, "next_time nonzero with no slot pending")

endmodule
